### design/bfsp_pkg.sv
package bfsp_pkg;

    // graph size, rows beyond it are held but not searched
    localparam int NUM_VERTICES = 8;
    localparam int NUM_ROWS     = 8;
    localparam int QAW          = (NUM_VERTICES > 1) ? $clog2(NUM_VERTICES) : 1;
    localparam int CW           = 4;

    localparam logic [NUM_VERTICES-1:0] VMASK = {NUM_VERTICES{1'b1}};
    localparam logic [CW-1:0] NV_C       = CW'(NUM_VERTICES);

    localparam logic [7:0] ROW_RESET [NUM_ROWS] = '{
        8'd70, 8'd13, 8'd3, 8'd18, 8'd40, 8'd80, 8'd33, 8'd0
    };

    // result kinds
    localparam logic [1:0] KIND_VISIT = 2'd0;
    localparam logic [1:0] KIND_PATH  = 2'd1;
    localparam logic [1:0] KIND_MISS  = 2'd2;

    // datapath actions
    localparam logic [2:0] ACT_START    = 3'd0;
    localparam logic [2:0] ACT_DEQ      = 3'd1;
    localparam logic [2:0] ACT_SCAN     = 3'd2;
    localparam logic [2:0] ACT_VISIT    = 3'd3;
    localparam logic [2:0] ACT_PATHINIT = 3'd4;
    localparam logic [2:0] ACT_MISS     = 3'd5;
    localparam logic [2:0] ACT_PATH     = 3'd6;

    // hold conditions
    localparam logic [1:0] WAIT_NONE = 2'd0;
    localparam logic [1:0] WAIT_IN   = 2'd1;
    localparam logic [1:0] WAIT_OUT  = 2'd2;

    // branch conditions
    localparam logic [2:0] BR_NONE     = 3'd0;
    localparam logic [2:0] BR_QEMPTY   = 3'd1;
    localparam logic [2:0] BR_PEND     = 3'd2;
    localparam logic [2:0] BR_NOTFOUND = 3'd3;
    localparam logic [2:0] BR_PATHEND  = 3'd4;

    // program steps
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_DEQ      = 3'd1;
    localparam logic [2:0] ST_SCAN     = 3'd2;
    localparam logic [2:0] ST_VISIT    = 3'd3;
    localparam logic [2:0] ST_CHECK    = 3'd4;
    localparam logic [2:0] ST_MISS     = 3'd5;
    localparam logic [2:0] ST_PATH     = 3'd6;

    typedef struct packed {
        logic [2:0] act;
        logic [1:0] wt;
        logic [2:0] br;
        logic [2:0] br_addr;
        logic [2:0] nx_addr;
    } ucode_t;

    typedef struct packed {
        logic [2:0] act;
        logic       go;
    } ctl_t;

    typedef struct packed {
        logic q_empty;
        logic pend;
        logic not_found;
        logic path_end;
        logic out_free;
    } stat_t;

    function automatic ucode_t ucode_rom(input logic [2:0] step);
        ucode_t w;
        unique case (step)
            ST_IDLE:  w = '{ACT_START,    WAIT_IN,   BR_NONE,     ST_IDLE,  ST_DEQ};
            ST_DEQ:   w = '{ACT_DEQ,      WAIT_NONE, BR_QEMPTY,   ST_CHECK, ST_SCAN};
            ST_SCAN:  w = '{ACT_SCAN,     WAIT_NONE, BR_PEND,     ST_SCAN,  ST_VISIT};
            ST_VISIT: w = '{ACT_VISIT,    WAIT_OUT,  BR_NONE,     ST_IDLE,  ST_DEQ};
            ST_CHECK: w = '{ACT_PATHINIT, WAIT_NONE, BR_NOTFOUND, ST_MISS,  ST_PATH};
            ST_MISS:  w = '{ACT_MISS,     WAIT_OUT,  BR_NONE,     ST_IDLE,  ST_IDLE};
            ST_PATH:  w = '{ACT_PATH,     WAIT_OUT,  BR_PATHEND,  ST_IDLE,  ST_PATH};
            default:  w = '{ACT_START,    WAIT_NONE, BR_NONE,     ST_IDLE,  ST_IDLE};
        endcase
        return w;
    endfunction

endpackage

### design/bfsp_useq.sv
module bfsp_useq (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  bfsp_pkg::stat_t stat,
    output bfsp_pkg::ctl_t  ctl
);

    logic [2:0]       step_reg;
    logic [2:0]       step_next;
    bfsp_pkg::ucode_t uw;
    logic             wait_ok;
    logic             br_taken;

    assign uw = bfsp_pkg::ucode_rom(step_reg);

    always_comb
    begin
        unique case (uw.wt)
            bfsp_pkg::WAIT_IN:  wait_ok = in_valid;
            bfsp_pkg::WAIT_OUT: wait_ok = stat.out_free;
            default:            wait_ok = 1'b1;
        endcase
    end

    always_comb
    begin
        unique case (uw.br)
            bfsp_pkg::BR_QEMPTY:   br_taken = stat.q_empty;
            bfsp_pkg::BR_PEND:     br_taken = stat.pend;
            bfsp_pkg::BR_NOTFOUND: br_taken = stat.not_found;
            bfsp_pkg::BR_PATHEND:  br_taken = stat.path_end;
            default:               br_taken = 1'b0;
        endcase
    end

    always_comb
    begin
        if (!wait_ok)
        begin
            step_next = step_reg;
        end
        else if (br_taken)
        begin
            step_next = uw.br_addr;
        end
        else
        begin
            step_next = uw.nx_addr;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= bfsp_pkg::ST_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    assign ctl.act = uw.act;
    assign ctl.go  = wait_ok;

endmodule

### design/bfsp_dpath.sv
module bfsp_dpath (
    input  logic            clk,
    input  logic            rst_n,
    input  bfsp_pkg::ctl_t  ctl,
    input  logic [2:0]      target_vertex,
    input  logic            cfg_valid,
    input  logic [2:0]      cfg_index,
    input  logic [7:0]      cfg_data,
    input  logic            out_ready,
    output bfsp_pkg::stat_t stat,
    output logic            out_valid,
    output logic [1:0]      kind,
    output logic [2:0]      vertex,
    output logic            found,
    output logic            last
);

    localparam int N = bfsp_pkg::NUM_VERTICES;

    logic [7:0]              adj_reg [bfsp_pkg::NUM_ROWS];
    logic [N-1:0]            seen_reg;
    logic [2:0]              queue_reg [N];
    logic [2:0]              parent_reg [N];
    logic [3:0]              head_reg;
    logic [3:0]              tail_reg;
    logic                    found_reg;
    logic [2:0]              target_reg;
    logic [2:0]              node_reg;
    logic [N-1:0]            row_reg;
    logic [2:0]              v_reg;
    logic [2:0]              steps_reg;

    logic                    out_valid_reg;
    logic [1:0]              kind_reg;
    logic [2:0]              vertex_reg;
    logic                    found_out_reg;
    logic                    last_reg;

    logic [N-1:0]            pend;
    logic [2:0]              pick;
    logic [2:0]              head_node;
    logic                    q_empty;
    logic                    scan_hit;
    logic                    path_end;
    logic                    out_free;
    logic                    emit;
    logic [7:0]              cur_row;

    assign pend = row_reg & ~seen_reg;

    // lowest pending neighbor
    always_comb
    begin
        pick = '0;
        for (int j = N - 1; j >= 0; j--)
        begin
            if (pend[j])
            begin
                pick = 3'(j);
            end
        end
    end

    assign q_empty   = (head_reg >= tail_reg) || (head_reg >= bfsp_pkg::NV_C);
    assign scan_hit  = (|pend) && (tail_reg < bfsp_pkg::NV_C);
    assign path_end  = (v_reg == 3'd0) || (({1'b0, steps_reg} + 4'd1) >= bfsp_pkg::NV_C);
    assign head_node = queue_reg[head_reg[bfsp_pkg::QAW-1:0]];
    assign cur_row   = adj_reg[head_node];
    assign out_free  = !out_valid_reg || out_ready;

    assign emit = ctl.go && ((ctl.act == bfsp_pkg::ACT_VISIT) ||
                             (ctl.act == bfsp_pkg::ACT_MISS) ||
                             (ctl.act == bfsp_pkg::ACT_PATH));

    assign stat.q_empty   = q_empty;
    assign stat.pend      = scan_hit;
    assign stat.not_found = !found_reg;
    assign stat.path_end  = path_end;
    assign stat.out_free  = out_free;

    // configuration rows
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < bfsp_pkg::NUM_ROWS; i++)
            begin
                adj_reg[i] <= bfsp_pkg::ROW_RESET[i];
            end
        end
        else if (cfg_valid)
        begin
            adj_reg[cfg_index] <= cfg_data;
        end
    end

    // search control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_reg  <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            found_reg <= 1'b0;
        end
        else if (ctl.go)
        begin
            case (ctl.act)
                bfsp_pkg::ACT_START:
                begin
                    seen_reg  <= N'(1);
                    head_reg  <= '0;
                    tail_reg  <= 4'd1;
                    found_reg <= 1'b0;
                end
                bfsp_pkg::ACT_DEQ:
                begin
                    if (!q_empty)
                    begin
                        head_reg <= head_reg + 4'd1;
                        if (head_node == target_reg)
                        begin
                            found_reg <= 1'b1;
                        end
                    end
                end
                bfsp_pkg::ACT_SCAN:
                begin
                    if (scan_hit)
                    begin
                        seen_reg[pick] <= 1'b1;
                        tail_reg       <= tail_reg + 4'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // queue, parents and walk registers
    always_ff @(posedge clk)
    begin
        if (ctl.go)
        begin
            case (ctl.act)
                bfsp_pkg::ACT_START:
                begin
                    queue_reg[0] <= 3'd0;
                    target_reg   <= target_vertex;
                end
                bfsp_pkg::ACT_DEQ:
                begin
                    if (!q_empty)
                    begin
                        node_reg <= head_node;
                        row_reg  <= cur_row[N-1:0] & bfsp_pkg::VMASK;
                    end
                end
                bfsp_pkg::ACT_SCAN:
                begin
                    if (scan_hit)
                    begin
                        queue_reg[tail_reg[bfsp_pkg::QAW-1:0]] <= pick;
                        parent_reg[pick[bfsp_pkg::QAW-1:0]]    <= node_reg;
                    end
                end
                bfsp_pkg::ACT_PATHINIT:
                begin
                    v_reg     <= target_reg;
                    steps_reg <= '0;
                end
                bfsp_pkg::ACT_PATH:
                begin
                    if (!path_end)
                    begin
                        v_reg     <= parent_reg[v_reg[bfsp_pkg::QAW-1:0]];
                        steps_reg <= steps_reg + 3'd1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            case (ctl.act)
                bfsp_pkg::ACT_VISIT:
                begin
                    kind_reg      <= bfsp_pkg::KIND_VISIT;
                    vertex_reg    <= node_reg;
                    found_out_reg <= found_reg;
                    last_reg      <= 1'b0;
                end
                bfsp_pkg::ACT_MISS:
                begin
                    kind_reg      <= bfsp_pkg::KIND_MISS;
                    vertex_reg    <= target_reg;
                    found_out_reg <= 1'b0;
                    last_reg      <= 1'b1;
                end
                default:
                begin
                    kind_reg      <= bfsp_pkg::KIND_PATH;
                    vertex_reg    <= v_reg;
                    found_out_reg <= 1'b1;
                    last_reg      <= path_end;
                end
            endcase
        end
    end

    assign out_valid = out_valid_reg;
    assign kind      = kind_reg;
    assign vertex    = vertex_reg;
    assign found     = found_out_reg;
    assign last      = last_reg;

endmodule

### design/bfs_search_with_path_unit.sv
// breadth-first search over an 8-vertex graph kept as eight adjacency rows
// configuration: cfg_valid/cfg_ready transfer writes row cfg_index with cfg_data,
//   bit j of a row marks an edge to vertex j; cfg_ready is always high
// request: one in_valid/in_ready transfer carries target_vertex; the search
//   starts at vertex 0 and in_ready stays low until the request's last result
//   has been loaded into the output register
// results: out_valid/out_ready transfers of kind, vertex, found and last;
//   first every reached vertex in visit order (kind visit), then either the
//   parent path from the target back to vertex 0 (kind path) or one not-found
//   summary; the final result of a request has last set
// program: a small microcode program steps the datapath one control word per
//   cycle unless a step waits for a request or a free output register; a start
//   step, per reached vertex a dequeue step, a scan step per newly discovered
//   neighbor, an empty scan step and an emit step, then a dequeue step that
//   finds the queue empty, a check step and a step per path or summary result
// stalls: a held result blocks the next emit step, nothing is dropped
// reset: rows return to their default graph, the program returns to idle
//   and the output register empties
module bfs_search_with_path_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [2:0] target_vertex,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [1:0] kind,
    output logic [2:0] vertex,
    output logic       found,
    output logic       last,
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic [2:0] cfg_index,
    input  logic [7:0] cfg_data
);

    bfsp_pkg::ctl_t  ctl;
    bfsp_pkg::stat_t stat;

    // sequencer: step counter, control store and branch logic
    bfsp_useq u_useq (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .stat     (stat),
        .ctl      (ctl)
    );

    // datapath: rows, visited set, queue, parents and result register
    bfsp_dpath u_dpath (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctl           (ctl),
        .target_vertex (target_vertex),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .out_ready     (out_ready),
        .stat          (stat),
        .out_valid     (out_valid),
        .kind          (kind),
        .vertex        (vertex),
        .found         (found),
        .last          (last)
    );

    // a request is taken only by the idle step of the program
    assign in_ready  = (ctl.act == bfsp_pkg::ACT_START);
    assign cfg_ready = 1'b1;

endmodule
